@@ design/sbsh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Word type, round constants, initial hash value and the SHA-256 mixing
// functions shared by the hasher.
// ----------------------------------------------------------------------------
package sbsh_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 61;
    localparam int ROUNDS  = 64;
    localparam int SCHED_N = 16;
    localparam int HASH_N  = 8;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam count_t COUNT_MAX = '1;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam word_t K_TABLE [ROUNDS] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam word_t IV_TABLE [HASH_N] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    function automatic word_t big_sig0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sig1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sig0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sig1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

@@ design/sha256_byte_stream_hasher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Absorbs one message byte per word, runs one compression round per cycle,
// pads on end of message and returns the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// Every 64th byte starts a compression of the block: 64 rounds through the
// single round unit, then a fold of the result into the chaining value, during
// which s_ready is low. An end-of-message word starts padding: one pad byte
// per cycle outside compressions, through the same byte path (up to 64, or 72
// when the length no longer fits the current block), each full block
// compressed as above, then the eight digest words are offered on m_*, one per
// cycle while m_ready is high. The hasher returns to its initial state after
// the eighth word is taken.
module sha256_byte_stream_hasher
    import sbsh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_has_byte,
    input  wire logic        s_end_of_message,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word,
    output logic             m_too_long
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] ret_reg, ret_next;
    count_t     count_reg, count_next;
    logic       ovf_reg, ovf_next;
    logic [5:0] pos_reg, pos_next;
    logic       pad_first_reg, pad_first_next;
    logic       len_ok_reg, len_ok_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] oidx_reg, oidx_next;
    word_t      chain_reg [HASH_N];
    word_t      chain_next [HASH_N];

    logic [23:0] acc_reg, acc_next;
    word_t       sched_reg [SCHED_N];
    word_t       sched_next [SCHED_N];
    word_t       var_reg [HASH_N];
    word_t       var_next [HASH_N];

    logic        push_en;
    logic [7:0]  push_byte;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;
    logic        len_phase;
    word_t       w_new, t1, t2;

    assign len_bits = {count_reg, 3'b000};
    assign len_byte = len_bits[{~pos_reg[2:0], 3'b000} +: 8];
    assign len_phase = len_ok_reg && (pos_reg[5:3] == 3'b111);

    // round unit
    always_comb begin
        w_new = small_sig1(sched_reg[14]) + sched_reg[9] + small_sig0(sched_reg[1])
              + sched_reg[0];
        t1 = var_reg[7] + big_sig1(var_reg[4])
           + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
           + K_TABLE[rnd_reg] + sched_reg[0];
        t2 = big_sig0(var_reg[0])
           + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]));
    end

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        pad_first_next = pad_first_reg;
        len_ok_next    = len_ok_reg;
        rnd_next       = rnd_reg;
        oidx_next      = oidx_reg;
        acc_next       = acc_reg;
        chain_next     = chain_reg;
        sched_next     = sched_reg;
        var_next       = var_reg;
        push_en        = 1'b0;
        push_byte      = 8'h00;
        s_ready        = 1'b0;
        m_valid        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_has_byte) begin
                        if (count_reg == COUNT_MAX) begin
                            ovf_next = 1'b1;
                        end else begin
                            push_en    = 1'b1;
                            push_byte  = s_data_byte;
                            count_next = count_reg + count_t'(1);
                        end
                    end
                    if (push_en && pos_reg == 6'd63) begin
                        state_next = ST_ROUND;
                        ret_next   = s_end_of_message ? ST_PAD : ST_IDLE;
                    end else if (s_end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                if (pad_first_reg) begin
                    push_byte      = PAD_BYTE;
                    pad_first_next = 1'b0;
                    if (pos_reg[5:3] != 3'b111) begin
                        len_ok_next = 1'b1;
                    end
                end else if (len_phase) begin
                    push_byte = len_byte;
                end else begin
                    push_byte = 8'h00;
                end
                if (pos_reg == 6'd63) begin
                    state_next = ST_ROUND;
                    // length bytes end the final block; otherwise it goes in the next one
                    ret_next    = (!pad_first_reg && len_phase) ? ST_OUT : ST_PAD;
                    len_ok_next = 1'b1;
                end
            end
            ST_ROUND: begin
                for (int i = 0; i < SCHED_N - 1; i++) begin
                    sched_next[i] = sched_reg[i+1];
                end
                sched_next[SCHED_N-1] = w_new;
                var_next[7] = var_reg[6];
                var_next[6] = var_reg[5];
                var_next[5] = var_reg[4];
                var_next[4] = var_reg[3] + t1;
                var_next[3] = var_reg[2];
                var_next[2] = var_reg[1];
                var_next[1] = var_reg[0];
                var_next[0] = t1 + t2;
                rnd_next    = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                for (int i = 0; i < HASH_N; i++) begin
                    chain_next[i] = chain_reg[i] + var_reg[i];
                end
                state_next = ret_reg;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        chain_next     = IV_TABLE;
                        count_next     = '0;
                        ovf_next       = 1'b0;
                        pos_next       = '0;
                        pad_first_next = 1'b1;
                        len_ok_next    = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // byte path: pack big-endian, shift each full word into the schedule line
        if (push_en) begin
            acc_next = {acc_reg[15:0], push_byte};
            pos_next = pos_reg + 6'd1;
            if (pos_reg[1:0] == 2'b11) begin
                for (int i = 0; i < SCHED_N - 1; i++) begin
                    sched_next[i] = sched_reg[i+1];
                end
                sched_next[SCHED_N-1] = {acc_reg, push_byte};
            end
            if (pos_reg == 6'd63) begin
                var_next = chain_reg;
                rnd_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pos_reg       <= '0;
            pad_first_reg <= 1'b1;
            len_ok_reg    <= 1'b0;
            rnd_reg       <= '0;
            oidx_reg      <= '0;
            chain_reg     <= IV_TABLE;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            pos_reg       <= pos_next;
            pad_first_reg <= pad_first_next;
            len_ok_reg    <= len_ok_next;
            rnd_reg       <= rnd_next;
            oidx_reg      <= oidx_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        sched_reg <= sched_next;
        var_reg   <= var_next;
    end

    assign m_digest_word = chain_reg[oidx_reg];
    assign m_word_index  = oidx_reg;
    assign m_last_word   = (oidx_reg == 3'd7);
    assign m_too_long    = ovf_reg;

endmodule

`default_nettype wire
